// File: rtl/core/pbpm_pkg.sv
`default_nettype none
package pbpm_pkg;

   localparam int LEVEL_FRAC_BITS = 16;
   localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
   localparam int DIV_CNT_W       = $clog2(LEVEL_FRAC_BITS + 1);

   localparam int REQ_DATA_W = 8;
   // level (17) + peak (32) + supported (1), padded to whole bytes
   localparam int RSP_FIELDS_W = LEVEL_W + 32 + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_KIND  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIG_ENDIAN   = 2'd2;

   localparam logic [31:0] FS_U8  = 32'd255;
   localparam logic [31:0] FS_U16 = 32'd65535;
   localparam logic [31:0] FS_U32 = 32'hffff_ffff;
   localparam logic [31:0] FS_S8  = 32'd127;
   localparam logic [31:0] FS_S16 = 32'd32767;
   localparam logic [31:0] FS_S32 = 32'h7fff_ffff;

   typedef enum logic [1:0] {
      WIDTH_8   = 2'd0,
      WIDTH_16  = 2'd1,
      WIDTH_32  = 2'd2,
      WIDTH_BAD = 2'd3
   } width_code_type;

   typedef enum logic [1:0] {
      KIND_UNSIGNED = 2'd0,
      KIND_SIGNED   = 2'd1,
      KIND_FLOAT    = 2'd2,
      KIND_UNKNOWN  = 2'd3
   } sample_kind_type;

   typedef struct packed {
      width_code_type  width;
      sample_kind_type kind;
      logic            big_endian;
   } fmt_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] raw;
   } sample_type;

   // zero means the format has no full scale
   function automatic logic [31:0] full_scale(input fmt_type fmt);
      logic [31:0] fs;
      fs = '0;
      unique case (fmt.kind)
         KIND_UNSIGNED: begin
            unique case (fmt.width)
               WIDTH_8:  fs = FS_U8;
               WIDTH_16: fs = FS_U16;
               WIDTH_32: fs = FS_U32;
               default:  fs = '0;
            endcase
         end
         KIND_SIGNED: begin
            unique case (fmt.width)
               WIDTH_8:  fs = FS_S8;
               WIDTH_16: fs = FS_S16;
               WIDTH_32: fs = FS_S32;
               default:  fs = '0;
            endcase
         end
         KIND_FLOAT: fs = (fmt.width == WIDTH_32) ? FS_S32 : '0;
         default:    fs = '0;
      endcase
      return fs;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/pcm_byte_stream_peak_meter_unit.sv
`default_nettype none
// Peak level meter over a byte stream of PCM samples.
// Throughput: one byte per cycle while a buffer streams in.
// Result: after the edge that takes a last byte the unit passes S_FLUSH, S_DIV and S_OUT
//   before rsp_tvalid rises; in S_DIV the divider takes one quotient bit per cycle. An
//   unsupported format skips S_DIV. req_tready stays low until then (longer while a result waits).
// Reset: synchronous, active high; format returns to 16-bit signed little endian.
module pcm_byte_stream_peak_meter_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [pbpm_pkg::REQ_DATA_W-1:0]     req_tdata,  // [7:0] byte_in
   input  wire logic                                req_tlast,  // last_byte
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [16:0] level_q16, [48:17] peak_clamped, [49] format_supported, rest zero
   output logic [pbpm_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_wen,
   input  wire logic [pbpm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pbpm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pbpm_pkg::*;

   typedef enum logic [1:0] {
      S_RUN,
      S_FLUSH,
      S_DIV,
      S_OUT
   } state_type;

   state_type       state_ff, state_in;
   fmt_type         fmt_ff, fmt_in;
   logic            cfg_clear;
   logic            req_accept;
   sample_type      sample;
   logic [31:0]     mag;
   logic [31:0]     fs;
   logic [31:0]     peak_ff, peak_in;
   logic [31:0]     peak_upd;
   logic [31:0]     clamped;
   logic [LEVEL_W-1:0] held_ff, held_in;
   logic [LEVEL_W-1:0] res_level_ff, res_level_in;
   logic [31:0]     res_peak_ff, res_peak_in;
   logic            res_sup_ff, res_sup_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic            div_start;
   logic            div_done;
   logic [LEVEL_W-1:0] div_quo;

   assign req_tready = (state_ff == S_RUN);
   assign req_accept = req_tvalid & req_tready;
   assign fs         = full_scale(fmt_ff);

   always_comb begin
      fmt_in    = fmt_ff;
      cfg_clear = 1'b0;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_SAMPLE_WIDTH: begin
               fmt_in.width = width_code_type'(csr_wdata);
               cfg_clear    = 1'b1;
            end
            CSR_SAMPLE_KIND: begin
               fmt_in.kind = sample_kind_type'(csr_wdata);
               cfg_clear   = 1'b1;
            end
            CSR_BIG_ENDIAN: begin
               fmt_in.big_endian = csr_wdata[0];
               cfg_clear         = 1'b1;
            end
            default: cfg_clear = 1'b0;
         endcase
      end
   end

   pbpm_assembler u_assembler (
      .clock      (clock),
      .reset      (reset),
      .fmt        (fmt_ff),
      .byte_valid (req_accept),
      .byte_data  (req_tdata[7:0]),
      .byte_last  (req_tlast),
      .clear      (cfg_clear),
      .sample     (sample)
   );

   pbpm_magnitude u_magnitude (
      .fmt (fmt_ff),
      .raw (sample.raw),
      .mag (mag)
   );

   pbpm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clamped),
      .divisor  (fs),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      peak_upd = (sample.valid && fs != '0 && mag > peak_ff) ? mag : peak_ff;
      clamped  = (peak_upd < fs) ? peak_upd : fs;
   end

   always_comb begin
      state_in     = state_ff;
      peak_in      = peak_upd;
      held_in      = held_ff;
      res_level_in = res_level_ff;
      res_peak_in  = res_peak_ff;
      res_sup_in   = res_sup_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         S_RUN: begin
            if (req_accept && req_tlast) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            // the last sample's peak update lands here
            peak_in = '0;
            if (fs != '0) begin
               div_start   = 1'b1;
               res_peak_in = clamped;
               res_sup_in  = 1'b1;
               state_in    = S_DIV;
            end else begin
               res_level_in = held_ff;
               res_peak_in  = '0;
               res_sup_in   = 1'b0;
               state_in     = S_OUT;
            end
         end
         S_DIV: begin
            if (div_done) begin
               held_in      = div_quo;
               res_level_in = div_quo;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({res_sup_ff, res_peak_ff, res_level_ff});
               state_in     = S_RUN;
            end
         end
         default: state_in = S_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_RUN;
         fmt_ff.width      <= WIDTH_16;
         fmt_ff.kind       <= KIND_SIGNED;
         fmt_ff.big_endian <= 1'b0;
         peak_ff           <= '0;
         held_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fmt_ff       <= fmt_in;
         peak_ff      <= peak_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_level_ff <= res_level_in;
      res_peak_ff  <= res_peak_in;
      res_sup_ff   <= res_sup_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/pbpm_assembler.sv
`default_nettype none
module pbpm_assembler (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pbpm_pkg::fmt_type  fmt,
   input  wire logic               byte_valid,
   input  wire logic [7:0]         byte_data,
   input  wire logic               byte_last,
   input  wire logic               clear,
   output pbpm_pkg::sample_type    sample
);
   import pbpm_pkg::*;

   logic [1:0]  pos_ff, pos_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] asm_next;
   logic        done;
   sample_type  sample_ff, sample_in;

   always_comb begin
      if (fmt.big_endian) begin
         asm_next = {asm_ff[23:0], byte_data};
      end else begin
         asm_next = asm_ff | ({24'b0, byte_data} << {pos_ff, 3'b000});
      end
      unique case (fmt.width)
         WIDTH_8:  done = 1'b1;
         WIDTH_16: done = (pos_ff >= 2'd1);
         default:  done = (pos_ff == 2'd3);
      endcase
   end

   always_comb begin
      pos_in          = pos_ff;
      asm_in          = asm_ff;
      sample_in.valid = 1'b0;
      sample_in.raw   = sample_ff.raw;
      if (clear) begin
         pos_in = '0;
         asm_in = '0;
      end else if (byte_valid) begin
         if (done) begin
            sample_in.valid = 1'b1;
            sample_in.raw   = asm_next;
            pos_in          = '0;
            asm_in          = '0;
         end else begin
            pos_in = pos_ff + 2'd1;
            asm_in = asm_next;
         end
         // partial sample at the end of a buffer is dropped
         if (byte_last) begin
            pos_in = '0;
            asm_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         asm_ff          <= '0;
         sample_ff.valid <= 1'b0;
      end else begin
         pos_ff          <= pos_in;
         asm_ff          <= asm_in;
         sample_ff.valid <= sample_in.valid;
      end
      sample_ff.raw <= sample_in.raw;
   end

   assign sample = sample_ff;

endmodule
`default_nettype wire

// File: rtl/core/pbpm_magnitude.sv
`default_nettype none
module pbpm_magnitude (
   input  wire pbpm_pkg::fmt_type  fmt,
   input  wire logic [31:0]        raw,
   output logic [31:0]             mag
);
   import pbpm_pkg::*;

   logic [7:0]  expo;
   logic [22:0] frac;
   logic [23:0] mant;
   logic [7:0]  eff_expo;
   logic [7:0]  shamt;
   logic [54:0] prod;
   logic [54:0] shifted;
   logic [31:0] float_mag;
   logic [31:0] sign_bit;
   logic [31:0] neg_mag;
   logic [31:0] int_mag;

   always_comb begin
      expo     = raw[30:23];
      frac     = raw[22:0];
      eff_expo = (expo == 8'd0) ? 8'd1 : expo;
      mant     = (expo == 8'd0) ? {1'b0, frac} : {1'b1, frac};
      // mant * (2^31 - 1) without a multiplier
      prod     = {mant, 31'b0} - {31'b0, mant};
      shamt    = 8'd150 - eff_expo;
      shifted  = prod >> shamt[5:0];
      if (expo == 8'hff) begin
         float_mag = (frac != '0) ? 32'd0 : FS_S32;
      end else if (expo >= 8'd127) begin
         float_mag = FS_S32;
      end else if (shamt >= 8'd55) begin
         float_mag = 32'd0;
      end else begin
         float_mag = shifted[31:0];
      end
   end

   always_comb begin
      unique case (fmt.width)
         WIDTH_8:  sign_bit = 32'h0000_0080;
         WIDTH_16: sign_bit = 32'h0000_8000;
         default:  sign_bit = 32'h8000_0000;
      endcase
      neg_mag = sign_bit - (raw & (sign_bit - 32'd1));
      if ((raw & sign_bit) == '0) begin
         int_mag = raw;
      end else if (neg_mag == sign_bit) begin
         int_mag = sign_bit - 32'd1;
      end else begin
         int_mag = neg_mag;
      end
   end

   always_comb begin
      unique case (fmt.kind)
         KIND_FLOAT:  mag = float_mag;
         KIND_SIGNED: mag = int_mag;
         default:     mag = raw;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/pbpm_divider.sv
`default_nettype none
module pbpm_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [31:0]                   dividend,
   input  wire logic [31:0]                   divisor,
   output logic                               done,
   output logic [pbpm_pkg::LEVEL_W-1:0]       quotient
);
   import pbpm_pkg::*;

   // restoring divide of (dividend << LEVEL_FRAC_BITS) / divisor, dividend <= divisor,
   // one quotient bit per cycle through a single 33-bit compare/subtract
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          div_ff, div_in;
   logic [LEVEL_W-1:0]   quo_ff, quo_in;
   logic [32:0]          trial;
   logic [32:0]          diff;
   logic                 ge;

   always_comb begin
      trial = (cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      diff  = trial - {1'b0, div_ff};
      ge    = (trial >= {1'b0, div_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         div_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[31:0] : trial[31:0];
         quo_in = {quo_ff[LEVEL_W-2:0], ge};
         if (cnt_ff == DIV_CNT_W'(LEVEL_FRAC_BITS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// File: tb/tb_pcm_byte_stream_peak_meter_unit.sv
`timescale 1ns / 100ps
module tb_pcm_byte_stream_peak_meter_unit;
   import pbpm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = LEVEL_FRAC_BITS + 10;
   localparam int PHASES         = 8;
   localparam int PHASE_BYTES    = 75;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [31:0]        peak;
      logic               supported;
   } meter_reading_type;

   class level_scoreboard;
      width_code_type     width;
      sample_kind_type    kind;
      logic               msb_first;
      logic [1:0]         byte_pos;
      logic [31:0]        assembly;
      logic [31:0]        peak;
      logic [LEVEL_W-1:0] held_level;
      meter_reading_type  pending_readings[$];
      int                 errors;

      function new();
         width      = WIDTH_16;
         kind       = KIND_SIGNED;
         msb_first  = 1'b0;
         byte_pos   = '0;
         assembly   = '0;
         peak       = '0;
         held_level = '0;
         errors     = 0;
      endfunction

      // zero when the format has no full scale
      function logic [31:0] scale_of();
         if (width == WIDTH_BAD || kind == KIND_UNKNOWN) return '0;
         if (kind == KIND_FLOAT) return (width == WIDTH_32) ? FS_S32 : '0;
         if (kind == KIND_UNSIGNED)
            return (width == WIDTH_8) ? FS_U8 : (width == WIDTH_16) ? FS_U16 : FS_U32;
         return (width == WIDTH_8) ? FS_S8 : (width == WIDTH_16) ? FS_S16 : FS_S32;
      endfunction

      // floor(|x| * (2^31-1)), exact, saturating at 2^31-1 for |x| >= 1; NaN reads as zero
      function logic [31:0] float_to_fixed(logic [31:0] bits);
         logic [7:0]  ex;
         logic [63:0] mant;
         int          shift;
         ex = bits[30:23];
         if (ex == 8'hff) return (bits[22:0] != 0) ? 32'd0 : FS_S32;
         if (ex >= 8'd127) return FS_S32;
         if (ex == 8'd0) begin
            mant  = {41'd0, bits[22:0]};
            shift = 149;
         end else begin
            mant  = {40'd0, 1'b1, bits[22:0]};
            shift = 150 - ex;
         end
         if (shift >= 64) return '0;
         mant = (mant * 64'h7fff_ffff) >> shift;
         return mant[31:0];
      endfunction

      function logic [31:0] magnitude_of(logic [31:0] raw);
         logic [31:0] sign, mag;
         if (kind == KIND_FLOAT) return float_to_fixed(raw);
         if (kind == KIND_UNSIGNED) return raw;
         sign = (width == WIDTH_8) ? 32'h80 : (width == WIDTH_16) ? 32'h8000 : 32'h8000_0000;
         if ((raw & sign) == 0) return raw;
         mag = sign - (raw & (sign - 1));
         return (mag == sign) ? sign - 1 : mag;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_SAMPLE_WIDTH: width = width_code_type'(val);
            CSR_SAMPLE_KIND:  kind = sample_kind_type'(val);
            CSR_BIG_ENDIAN:   msb_first = val[0];
            default:          return;
         endcase
         // a format change drops the partial sample, the running peak survives
         byte_pos = '0;
         assembly = '0;
      endfunction

      function void take_byte(logic [7:0] b, logic last);
         logic [31:0]       fs, mag, clamped;
         logic [63:0]       ratio;
         int                nbytes;
         meter_reading_type r;
         fs     = scale_of();
         nbytes = (width == WIDTH_8) ? 1 : (width == WIDTH_16) ? 2 : 4;
         if (msb_first) assembly = {assembly[23:0], b};
         else assembly = assembly | ({24'd0, b} << (8 * byte_pos));
         if (byte_pos + 1 >= nbytes) begin
            mag = magnitude_of(assembly);
            if (fs != 0 && mag > peak) peak = mag;
            byte_pos = '0;
            assembly = '0;
         end else begin
            byte_pos = byte_pos + 2'd1;
         end
         if (!last) return;
         if (fs != 0) begin
            clamped      = (peak < fs) ? peak : fs;
            ratio        = ({32'd0, clamped} << LEVEL_FRAC_BITS) / {32'd0, fs};
            held_level   = ratio[LEVEL_W-1:0];
            r.level      = held_level;
            r.peak       = clamped;
            r.supported  = 1'b1;
         end else begin
            r.level      = held_level;
            r.peak       = '0;
            r.supported  = 1'b0;
         end
         pending_readings.push_back(r);
         peak     = '0;
         byte_pos = '0;
         assembly = '0;
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t level meter error: %s got %0h want %0h", $time, what, got, want);
         errors++;
      endtask

      task check_reading(logic [RSP_DATA_W-1:0] data);
         meter_reading_type want;
         if (pending_readings.size() == 0) begin
            report("reading with none pending, level", 32'(data[LEVEL_W-1:0]), '0);
            return;
         end
         want = pending_readings.pop_front();
         if (data[LEVEL_W-1:0] != want.level)
            report("level_q16", 32'(data[LEVEL_W-1:0]), 32'(want.level));
         if (data[LEVEL_W+31:LEVEL_W] != want.peak)
            report("peak_clamped", data[LEVEL_W+31:LEVEL_W], want.peak);
         if (data[LEVEL_W+32] != want.supported)
            report("format_supported", 32'(data[LEVEL_W+32]), 32'(want.supported));
      endtask
   endclass

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tlast  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_wen    = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   level_scoreboard sb = new();
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int stuck_cycles  = 0;

   pcm_byte_stream_peak_meter_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.take_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_reading(rsp_tdata);
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("pcm_byte_stream_peak_meter_unit: mismatch");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_sample(input logic [31:0] raw, input int nbytes, input logic be,
                              input logic last);
      int i;
      for (i = 0; i < nbytes; i++)
         send_byte(be ? raw[8*(nbytes-1-i) +: 8] : raw[8*i +: 8], last && i == nbytes - 1);
   endtask

   // drains all pending readings, then lets the unit settle before returning
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic set_format(input width_code_type w, input sample_kind_type k,
                             input logic be);
      logic [CSR_DATA_W-1:0] junk;
      logic                  upper;
      junk  = CSR_DATA_W'($urandom_range(3));
      upper = 1'($urandom_range(1));
      wait_idle();
      write_reg(CSR_SAMPLE_WIDTH, w);
      write_reg(CSR_SAMPLE_KIND, k);
      write_reg(CSR_BIG_ENDIAN, {upper, be});
      write_reg(CSR_UNUSED, junk);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [31:0] pick_sample(input int nbytes, input sample_kind_type k);
      logic [31:0] raw, top;
      int          pick;
      raw  = $urandom();
      pick = $urandom_range(7);
      top  = 32'h1 << (8 * nbytes - 1);
      case (pick)
         0: raw = '0;
         1: raw = '1;
         2: raw = top;
         3: raw = top - 1;
         4, 5: begin
            if (k == KIND_FLOAT) begin
               case ($urandom_range(4))
                  0: raw[30:23] = 8'h00;
                  1: raw[30:23] = 8'hff;
                  2: raw[30:23] = 8'd126;
                  3: raw[30:23] = 8'd127;
                  default: raw[30:23] = 8'd100 + 8'($urandom_range(25));
               endcase
               if (pick == 4) raw[22:0] = '0;
            end
         end
         default: ;
      endcase
      return raw;
   endfunction

   // well-formed buffer with random content; now and then a trailing partial sample
   task automatic send_buffer(input int nbytes, input sample_kind_type k, input logic be,
                              inout int count);
      int          nsamp, extra, s;
      logic [31:0] raw;
      nsamp = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(5, 1);
      extra = ($urandom_range(7) == 0) ? $urandom_range(nbytes - 1) : 0;
      for (s = 0; s < nsamp; s++)
         send_sample(pick_sample(nbytes, k), nbytes, be, s == nsamp - 1 && extra == 0);
      for (s = 0; s < extra; s++) begin
         raw = $urandom();
         send_byte(raw[7:0], s == extra - 1);
      end
      count += nsamp * nbytes + extra;
   endtask

   initial begin
      int              ph, sent, nbytes, tail, i;
      logic [1:0]      code;
      logic            be;
      logic [31:0]     raw;
      width_code_type  w;
      sample_kind_type k;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset format is 16-bit signed LE: most negative saturates, odd byte dropped
      send_sample(32'h8000, 2, 1'b0, 1'b0);
      send_byte(8'h01, 1'b1);
      set_format(WIDTH_8, KIND_UNSIGNED, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b1);
      set_format(WIDTH_8, KIND_SIGNED, 1'b1);
      send_byte(8'h80, 1'b1);
      set_format(WIDTH_32, KIND_UNSIGNED, 1'b1);
      send_sample(32'hffff_ffff, 4, 1'b1, 1'b1);
      // NaN counts as zero, then one half
      set_format(WIDTH_32, KIND_FLOAT, 1'b1);
      send_sample(32'h7fc0_0000, 4, 1'b1, 1'b0);
      send_sample(32'h3f00_0000, 4, 1'b1, 1'b1);
      // unsupported formats repeat the held level
      set_format(WIDTH_16, KIND_FLOAT, 1'b0);
      send_sample(32'h3412, 2, 1'b0, 1'b1);
      set_format(WIDTH_BAD, KIND_UNKNOWN, 1'b0);
      send_byte(8'h55, 1'b1);

      for (ph = 0; ph < PHASES; ph++) begin
         if ($urandom_range(5) == 0) begin
            code = 2'($urandom_range(3));
            w    = width_code_type'(code);
            code = 2'($urandom_range(3));
            k    = sample_kind_type'(code);
         end else begin
            code = 2'($urandom_range(2));
            k    = sample_kind_type'(code);
            code = 2'($urandom_range(2));
            w    = (k == KIND_FLOAT) ? WIDTH_32 : width_code_type'(code);
         end
         be = 1'($urandom_range(1));
         set_format(w, k, be);
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 74;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 74;
            end
            default: begin
               send_idle_pct = 20;
               stall_pct     = 20;
            end
         endcase
         nbytes = (w == WIDTH_8) ? 1 : (w == WIDTH_16) ? 2 : 4;
         sent   = 0;
         while (sent < PHASE_BYTES) send_buffer(nbytes, k, be, sent);
         // leave a buffer open so the next format change lands mid-buffer
         if ($urandom_range(1)) begin
            tail = $urandom_range(6, 1);
            for (i = 0; i < tail; i++) begin
               raw = $urandom();
               send_byte(raw[7:0], 1'b0);
            end
         end
      end

      wait_idle();
      if (sb.errors == 0) $display("pcm_byte_stream_peak_meter_unit: match");
      else $display("pcm_byte_stream_peak_meter_unit: mismatch");
      $finish;
   end

endmodule
